@@ hdl/lned_pkg.sv @@
// ============================================================================
// Line editor package
// Result kinds, field widths, register indexes, reset values and character constants for the line editor.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lned_pkg;

    // Result kinds carried on the command channel.
    localparam logic [2:0] KIND_ECHO    = 3'd0;
    localparam logic [2:0] KIND_ERASE   = 3'd1;
    localparam logic [2:0] KIND_NEWLINE = 3'd2;
    localparam logic [2:0] KIND_BELL    = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    // Field widths of one result, and the width of a stored character.
    localparam int KIND_W        = 3;
    localparam int CHAR_W        = 8;
    localparam int STORE_W       = 7;
    localparam int ERASE_COUNT_W = 6;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ERASE      = 2'd0;
    localparam logic [1:0] REG_WORD_ERASE = 2'd1;
    localparam logic [1:0] REG_KILL       = 2'd2;
    localparam logic [1:0] REG_EOF        = 2'd3;

    // Register reset values.
    localparam logic [7:0] ERASE_RESET      = 8'd127;
    localparam logic [7:0] WORD_ERASE_RESET = 8'd23;
    localparam logic [7:0] KILL_RESET       = 8'd21;
    localparam logic [7:0] EOF_RESET        = 8'd4;

    // Character classes.
    localparam logic [7:0] SPACE_CHAR     = 8'h20;
    localparam logic [7:0] PRINT_LOW      = 8'h20;
    localparam logic [7:0] PRINT_HIGH     = 8'h7E;
    localparam logic [6:0] SPACE_STORED   = 7'h20;

endpackage

`default_nettype wire

@@ hdl/line_editor_with_word_wrap_core.sv @@
// ============================================================================
// Line editor with word wrap
// Keeps a line of printable characters, answers received bytes with echo,
// erase, newline, bell and end commands, and moves the last word to a new line when the line is full.
// ============================================================================
//
//   Channel   Direction  Handshake            Payload
//   --------  ---------  -------------------  ---------------------------------
//   rx        in         rx_valid / rx_stall  rx_byte
//   cmd       out        cmd_valid/cmd_stall  kind, char_value, erase_count, last
//   apb       in/out     psel, penable        paddr, pwdata, prdata, pready
//
// A plain byte, erase or kill passes through decode and emit; a kill on an
// empty line goes back to idle from decode. Word erase and wrap walk the line
// backward through the single read port of the line store, a read and a check
// for each character, and a wrap then copies the word forward, a read and an
// echo for each character.
// Reset clears the length and restores the control characters; the line
// store is not cleared. A stall on cmd holds the sequencer until the
// result register empties; rx is taken only while the sequencer is idle.
//
`timescale 1ns / 1ps
`default_nettype none

module line_editor_with_word_wrap_core #(
    parameter int LINE_MAX = 40
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,

    output logic             cmd_valid,
    input  wire logic        cmd_stall,
    output logic [2:0]       kind,
    output logic [7:0]       char_value,
    output logic [5:0]       erase_count,
    output logic             last,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LW = $clog2(LINE_MAX + 1);
    localparam int AW = (LINE_MAX > 2) ? $clog2(LINE_MAX) : 1;
    localparam int SW = lned_pkg::STORE_W;
    localparam int CW = lned_pkg::ERASE_COUNT_W;

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_RD      = 4'd2;
    localparam logic [3:0] S_CHK     = 4'd3;
    localparam logic [3:0] S_FIN     = 4'd4;
    localparam logic [3:0] S_EMIT    = 4'd5;
    localparam logic [3:0] S_W_ECHO  = 4'd6;
    localparam logic [3:0] S_W_ERASE = 4'd7;
    localparam logic [3:0] S_W_NL    = 4'd8;
    localparam logic [3:0] S_C_RD    = 4'd9;
    localparam logic [3:0] S_C_ECHO  = 4'd10;
    localparam logic [3:0] S_C_LAST  = 4'd11;

    // Control registers.
    logic [7:0]    erase_char_reg, word_erase_char_reg, kill_char_reg, eof_char_reg;

    // Sequencer registers.
    logic [3:0]    state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] wend_reg, wend_next;
    logic [LW-1:0] j_reg, j_next;
    logic          phase_reg, phase_next;
    logic          wrap_reg, wrap_next;
    logic [7:0]    byte_reg, byte_next;
    logic [2:0]    pk_kind_reg, pk_kind_next;
    logic [CW-1:0] pk_cnt_reg, pk_cnt_next;

    // Result register.
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    kind_reg, kind_next;
    logic [7:0]    char_reg, char_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          last_reg, last_next;

    // Line store and its ports.
    logic [SW-1:0] line_mem [LINE_MAX];
    logic [SW-1:0] rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [SW-1:0] mem_wdata;

    // Helpers.
    logic          out_free, out_load;
    logic [2:0]    ld_kind;
    logic [7:0]    ld_char;
    logic [CW-1:0] ld_cnt;
    logic          ld_last;
    logic [LW-1:0] idx_m1, wlen, src_idx;
    logic          rd_space, printable, cfg_write;

    // ------------------------------------------------------------------------
    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_char_reg      <= lned_pkg::ERASE_RESET;
            word_erase_char_reg <= lned_pkg::WORD_ERASE_RESET;
            kill_char_reg       <= lned_pkg::KILL_RESET;
            eof_char_reg        <= lned_pkg::EOF_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                lned_pkg::REG_ERASE:      erase_char_reg      <= pwdata[7:0];
                lned_pkg::REG_WORD_ERASE: word_erase_char_reg <= pwdata[7:0];
                lned_pkg::REG_KILL:       kill_char_reg       <= pwdata[7:0];
                lned_pkg::REG_EOF:        eof_char_reg        <= pwdata[7:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            lned_pkg::REG_ERASE:      prdata = {24'd0, erase_char_reg};
            lned_pkg::REG_WORD_ERASE: prdata = {24'd0, word_erase_char_reg};
            lned_pkg::REG_KILL:       prdata = {24'd0, kill_char_reg};
            lned_pkg::REG_EOF:        prdata = {24'd0, eof_char_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Line store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= line_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------------
    // Shared scan arithmetic.
    assign idx_m1    = idx_reg - LW'(1);
    assign wlen      = wend_reg - idx_reg + LW'(1);
    assign src_idx   = idx_reg + j_reg;
    assign rd_space  = (rdata_reg == lned_pkg::SPACE_STORED);
    assign printable = byte_reg inside {[lned_pkg::PRINT_LOW:lned_pkg::PRINT_HIGH]};
    assign out_free  = !out_valid_reg || !cmd_stall;
    assign rx_stall  = (state_reg != S_IDLE);

    // ------------------------------------------------------------------------
    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        wend_next    = wend_reg;
        j_next       = j_reg;
        phase_next   = phase_reg;
        wrap_next    = wrap_reg;
        byte_next    = byte_reg;
        pk_kind_next = pk_kind_reg;
        pk_cnt_next  = pk_cnt_reg;
        out_load     = 1'b0;
        ld_kind      = lned_pkg::KIND_ECHO;
        ld_char      = 8'd0;
        ld_cnt       = '0;
        ld_last      = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (rx_valid)
                begin
                    byte_next  = rx_byte;
                    state_next = S_DECODE;
                end
            end

            // Classify the byte; most requests settle with a single result.
            S_DECODE:
            begin
                pk_kind_next = lned_pkg::KIND_BELL;
                pk_cnt_next  = '0;
                state_next   = S_EMIT;
                if (byte_reg == eof_char_reg && len_reg == '0)
                begin
                    pk_kind_next = lned_pkg::KIND_END;
                end
                else if (printable)
                begin
                    if (len_reg < LW'(LINE_MAX))
                    begin
                        mem_we       = 1'b1;
                        mem_waddr    = len_reg[AW-1:0];
                        mem_wdata    = byte_reg[SW-1:0];
                        len_next     = len_reg + LW'(1);
                        pk_kind_next = lned_pkg::KIND_ECHO;
                    end
                    else if (byte_reg != lned_pkg::SPACE_CHAR)
                    begin
                        idx_next   = len_reg;
                        phase_next = 1'b0;
                        wrap_next  = 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (byte_reg == erase_char_reg)
                begin
                    if (len_reg != '0)
                    begin
                        len_next     = len_reg - LW'(1);
                        pk_kind_next = lned_pkg::KIND_ERASE;
                        pk_cnt_next  = CW'(1);
                    end
                end
                else if (byte_reg == word_erase_char_reg)
                begin
                    if (len_reg != '0)
                    begin
                        idx_next   = len_reg;
                        phase_next = 1'b0;
                        wrap_next  = 1'b0;
                        state_next = S_RD;
                    end
                end
                else if (byte_reg == kill_char_reg)
                begin
                    if (len_reg != '0)
                    begin
                        pk_kind_next = lned_pkg::KIND_ERASE;
                        pk_cnt_next  = CW'(len_reg);
                        len_next     = '0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            // Backward scan: read the character left of the index.
            S_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_m1[AW-1:0];
                state_next = S_CHK;
            end

            // Skip trailing spaces, then the word in front of them.
            S_CHK:
            begin
                state_next = S_RD;
                if (!phase_reg)
                begin
                    idx_next = idx_m1;
                    if (!rd_space)
                    begin
                        phase_next = 1'b1;
                        wend_next  = idx_reg;
                    end
                    if (idx_m1 == '0)
                    begin
                        state_next = S_FIN;
                    end
                end
                else if (!rd_space)
                begin
                    idx_next = idx_m1;
                    if (idx_m1 == '0)
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            // A wrap needs a word that starts past column zero.
            S_FIN:
            begin
                if (wrap_reg)
                begin
                    if (idx_reg == '0)
                    begin
                        pk_kind_next = lned_pkg::KIND_BELL;
                        pk_cnt_next  = '0;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_W_ECHO;
                    end
                end
                else
                begin
                    pk_kind_next = lned_pkg::KIND_ERASE;
                    pk_cnt_next  = CW'(len_reg - idx_reg);
                    len_next     = idx_reg;
                    state_next   = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    ld_kind  = pk_kind_reg;
                    ld_char  = (pk_kind_reg == lned_pkg::KIND_ECHO) ? byte_reg : 8'd0;
                    ld_cnt   = pk_cnt_reg;
                    ld_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_W_ECHO:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_kind    = lned_pkg::KIND_ECHO;
                    ld_char    = byte_reg;
                    j_next     = '0;
                    state_next = S_W_ERASE;
                end
            end

            S_W_ERASE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_kind    = lned_pkg::KIND_ERASE;
                    ld_cnt     = CW'(wlen);
                    state_next = S_W_NL;
                end
            end

            S_W_NL:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_kind    = lned_pkg::KIND_NEWLINE;
                    state_next = S_C_RD;
                end
            end

            // Forward copy of the word to the start of the line.
            S_C_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = src_idx[AW-1:0];
                state_next = S_C_ECHO;
            end

            S_C_ECHO:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    ld_kind   = lned_pkg::KIND_ECHO;
                    ld_char   = {1'b0, rdata_reg};
                    mem_we    = 1'b1;
                    mem_waddr = j_reg[AW-1:0];
                    mem_wdata = rdata_reg;
                    j_next    = j_reg + LW'(1);
                    state_next = (j_reg + LW'(2) == wlen) ? S_C_LAST : S_C_RD;
                end
            end

            // The received byte closes the new line.
            S_C_LAST:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_kind    = lned_pkg::KIND_ECHO;
                    ld_char    = byte_reg;
                    ld_last    = 1'b1;
                    mem_we     = 1'b1;
                    mem_waddr  = j_reg[AW-1:0];
                    mem_wdata  = byte_reg[SW-1:0];
                    len_next   = wlen;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Result register update.
        out_valid_next = out_valid_reg && cmd_stall;
        kind_next      = kind_reg;
        char_next      = char_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            kind_next      = ld_kind;
            char_next      = ld_char;
            cnt_next       = ld_cnt;
            last_next      = ld_last;
        end
    end

    // ------------------------------------------------------------------------
    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and scan registers.
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        wend_reg    <= wend_next;
        j_reg       <= j_next;
        phase_reg   <= phase_next;
        wrap_reg    <= wrap_next;
        byte_reg    <= byte_next;
        pk_kind_reg <= pk_kind_next;
        pk_cnt_reg  <= pk_cnt_next;
        kind_reg    <= kind_next;
        char_reg    <= char_next;
        cnt_reg     <= cnt_next;
        last_reg    <= last_next;
    end

    assign cmd_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign char_value  = char_reg;
    assign erase_count = cnt_reg;
    assign last        = last_reg;

`ifndef SYNTH
    // The line never grows past its capacity.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(LINE_MAX))
        else $error("line length exceeds capacity");

    // An accepted byte is decoded in the next cycle.
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_valid && !rx_stall) |=> (state_reg == S_DECODE))
        else $error("accepted byte not decoded");

    // Only echo results carry a character.
    a_char_only_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && kind != lned_pkg::KIND_ECHO) |-> (char_value == 8'd0))
        else $error("character on a non-echo result");

    // The word copy never runs past the end of the word.
    a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C_ECHO) |-> (j_reg + LW'(1) < wlen))
        else $error("word copy ran past the word");
`endif

endmodule

`default_nettype wire
